[sv/jvm_subset_stack_executor_macros.svh]
// ----------------------------------------------------------------------------
// jvm subset stack executor assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef JVM_SUBSET_STACK_EXECUTOR_MACROS_SVH
`define JVM_SUBSET_STACK_EXECUTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define JVMX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define JVMX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/jvmx_pkg.sv]
// ----------------------------------------------------------------------------
// jvmx_pkg
// types, opcodes and operation classes of the jvm subset stack executor
// ----------------------------------------------------------------------------
package jvmx_pkg;

    // opcode bytes
    localparam logic [7:0] OP_ICONST_M1 = 8'h02;
    localparam logic [7:0] OP_ICONST_0  = 8'h03;
    localparam logic [7:0] OP_ICONST_5  = 8'h08;
    localparam logic [7:0] OP_BIPUSH    = 8'h10;
    localparam logic [7:0] OP_ILOAD_0   = 8'h1a;
    localparam logic [7:0] OP_ILOAD_3   = 8'h1d;
    localparam logic [7:0] OP_ISTORE_0  = 8'h3b;
    localparam logic [7:0] OP_ISTORE_3  = 8'h3e;
    localparam logic [7:0] OP_IADD      = 8'h60;
    localparam logic [7:0] OP_ISUB      = 8'h64;
    localparam logic [7:0] OP_IMUL      = 8'h68;
    localparam logic [7:0] OP_GOTO      = 8'ha7;
    localparam logic [7:0] OP_BR_LT     = 8'ha1;
    localparam logic [7:0] OP_IINC      = 8'h84;
    localparam logic [7:0] OP_IRETURN   = 8'hac;

    typedef enum logic [3:0] {
        K_NOP,
        K_PUSH,
        K_LOAD,
        K_STORE,
        K_ADD,
        K_SUB,
        K_MUL,
        K_GOTO,
        K_CMPLT,
        K_INC,
        K_RET
    } op_kind_t;

    typedef struct packed {
        logic [7:0]         command;
        logic signed [7:0]  push_byte;
        logic [7:0]         local_slot;
        logic signed [7:0]  increment;
        logic [15:0]        jump_step;
    } cmd_t;

    typedef struct packed {
        logic [15:0]        next_step;
        logic               halted;
        logic signed [31:0] return_value;
    } res_t;

    // classified instruction handed from front to back
    typedef struct packed {
        op_kind_t           kind;
        logic [31:0]        imm;
        logic [7:0]         slot;
        logic signed [7:0]  inc;
        logic [15:0]        target;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } queue_head_t;

endpackage

[sv/jvmx_ram.sv]
// ----------------------------------------------------------------------------
// jvmx_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module jvmx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/jvmx_front.sv]
// ----------------------------------------------------------------------------
// jvmx_front
// accepts instructions, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module jvmx_front #(
    parameter int LOCAL_COUNT = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  jvmx_pkg::cmd_t        cmd_data,
    output jvmx_pkg::queue_head_t head,
    input  logic                  pop
);

    jvmx_pkg::op_t dec_op;
    jvmx_pkg::op_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;

    // classify
    always_comb
    begin
        dec_op        = '0;
        dec_op.kind   = jvmx_pkg::K_NOP;
        dec_op.inc    = cmd_data.increment;
        dec_op.target = cmd_data.jump_step;
        unique case (cmd_data.command) inside
            [jvmx_pkg::OP_ICONST_M1:jvmx_pkg::OP_ICONST_5]:
            begin
                dec_op.kind = jvmx_pkg::K_PUSH;
                dec_op.imm  = {24'b0, cmd_data.command} - {24'b0, jvmx_pkg::OP_ICONST_0};
            end
            jvmx_pkg::OP_BIPUSH:
            begin
                dec_op.kind = jvmx_pkg::K_PUSH;
                dec_op.imm  = {{24{cmd_data.push_byte[7]}}, cmd_data.push_byte};
            end
            [jvmx_pkg::OP_ILOAD_0:jvmx_pkg::OP_ILOAD_3]:
            begin
                dec_op.kind = jvmx_pkg::K_LOAD;
                dec_op.slot = cmd_data.command - jvmx_pkg::OP_ILOAD_0;
            end
            [jvmx_pkg::OP_ISTORE_0:jvmx_pkg::OP_ISTORE_3]:
            begin
                dec_op.kind = jvmx_pkg::K_STORE;
                dec_op.slot = cmd_data.command - jvmx_pkg::OP_ISTORE_0;
            end
            jvmx_pkg::OP_IADD:      dec_op.kind = jvmx_pkg::K_ADD;
            jvmx_pkg::OP_ISUB:      dec_op.kind = jvmx_pkg::K_SUB;
            jvmx_pkg::OP_IMUL:      dec_op.kind = jvmx_pkg::K_MUL;
            jvmx_pkg::OP_GOTO:      dec_op.kind = jvmx_pkg::K_GOTO;
            jvmx_pkg::OP_BR_LT:     dec_op.kind = jvmx_pkg::K_CMPLT;
            jvmx_pkg::OP_IINC:
            begin
                // slot past the local store is dropped here
                if ({24'b0, cmd_data.local_slot} < 32'(LOCAL_COUNT))
                begin
                    dec_op.kind = jvmx_pkg::K_INC;
                    dec_op.slot = cmd_data.local_slot;
                end
            end
            jvmx_pkg::OP_IRETURN:   dec_op.kind = jvmx_pkg::K_RET;
            default:                dec_op.kind = jvmx_pkg::K_NOP;
        endcase
    end

    // two-entry queue
    assign cmd_ready = (count_reg != 2'd2);
    assign push      = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec_op;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.op    = entry_reg[rd_ptr_reg];

endmodule

[sv/jvmx_back.sv]
// ----------------------------------------------------------------------------
// jvmx_back
// executes queued operations on the stack and local rams, holds the result
// ----------------------------------------------------------------------------
module jvmx_back #(
    parameter int STACK_DEPTH = 256,
    parameter int LOCAL_COUNT = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jvmx_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output jvmx_pkg::res_t        res_data
);

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int LA_W = $clog2(LOCAL_COUNT);

    localparam logic [1:0] ST_HEAD = 2'd0;
    localparam logic [1:0] ST_RD1  = 2'd1;
    localparam logic [1:0] ST_RD2  = 2'd2;
    localparam logic [1:0] ST_MUL  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic [15:0]       step_reg;
    logic [15:0]       step_next;
    logic              stop_reg;
    logic              stop_next;
    logic [31:0]       ret_reg;
    logic [31:0]       ret_next;
    jvmx_pkg::op_t     op_reg;
    jvmx_pkg::op_t     op_next;
    logic [31:0]       a_reg;
    logic [31:0]       a_next;
    logic [31:0]       p_reg;
    logic [31:0]       p_next;
    logic              out_valid_reg;
    jvmx_pkg::res_t    out_reg;
    logic [LOCAL_COUNT-1:0] lval_reg;
    logic              lval_rd_reg;

    jvmx_pkg::op_t     cur;
    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [SP_W-1:0]   sp_p1;
    logic              out_free;
    logic              fin;
    logic              take_jump;

    logic              s_we;
    logic [SP_W-1:0]   s_waddr;
    logic [31:0]       s_wdata;
    logic [SP_W-1:0]   s_raddr;
    logic [31:0]       s_rdata;
    logic              l_we;
    logic [LA_W-1:0]   l_waddr;
    logic [31:0]       l_wdata;
    logic [LA_W-1:0]   l_raddr;
    logic [31:0]       l_rdata;
    logic [31:0]       l_word;

    function automatic logic [SP_W-1:0] sp_dec(input logic [SP_W-1:0] v);
        sp_dec = (v == '0) ? SP_W'(STACK_DEPTH - 1) : v - 1'b1;
    endfunction

    function automatic logic [SP_W-1:0] sp_inc(input logic [SP_W-1:0] v);
        sp_inc = (v == SP_W'(STACK_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    assign cur      = (state_reg == ST_HEAD) ? head.op : op_reg;
    assign sp_m1    = sp_dec(sp_reg);
    assign sp_m2    = sp_dec(sp_m1);
    assign sp_p1    = sp_inc(sp_reg);
    assign out_free = !out_valid_reg || res_ready;
    // never-written local entries read as zero
    assign l_word   = lval_rd_reg ? l_rdata : 32'd0;

    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        stop_next  = stop_reg;
        ret_next   = ret_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        p_next     = p_reg;
        pop        = 1'b0;
        fin        = 1'b0;
        take_jump  = 1'b0;
        s_we       = 1'b0;
        s_waddr    = sp_reg;
        s_wdata    = 32'd0;
        s_raddr    = sp_m1;
        l_we       = 1'b0;
        l_waddr    = cur.slot[LA_W-1:0];
        l_wdata    = 32'd0;
        l_raddr    = cur.slot[LA_W-1:0];

        unique case (state_reg)
            ST_HEAD:
            begin
                if (head.valid)
                begin
                    if (stop_reg || head.op.kind == jvmx_pkg::K_NOP
                        || head.op.kind == jvmx_pkg::K_PUSH
                        || head.op.kind == jvmx_pkg::K_GOTO)
                    begin
                        if (out_free)
                        begin
                            pop = 1'b1;
                            fin = 1'b1;
                            if (!stop_reg && head.op.kind == jvmx_pkg::K_PUSH)
                            begin
                                s_we    = 1'b1;
                                s_wdata = head.op.imm;
                                sp_next = sp_p1;
                            end
                            take_jump = (head.op.kind == jvmx_pkg::K_GOTO);
                        end
                    end
                    else
                    begin
                        // first operand read issued here
                        pop        = 1'b1;
                        op_next    = head.op;
                        state_next = ST_RD1;
                    end
                end
            end
            ST_RD1:
            begin
                if (op_reg.kind == jvmx_pkg::K_ADD || op_reg.kind == jvmx_pkg::K_SUB
                    || op_reg.kind == jvmx_pkg::K_MUL || op_reg.kind == jvmx_pkg::K_CMPLT)
                begin
                    a_next     = s_rdata;
                    s_raddr    = sp_m2;
                    state_next = ST_RD2;
                end
                else if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = ST_HEAD;
                    case (op_reg.kind)
                        jvmx_pkg::K_LOAD:
                        begin
                            s_we    = 1'b1;
                            s_wdata = l_word;
                            sp_next = sp_p1;
                        end
                        jvmx_pkg::K_STORE:
                        begin
                            l_we    = 1'b1;
                            l_wdata = s_rdata;
                            sp_next = sp_m1;
                        end
                        jvmx_pkg::K_INC:
                        begin
                            l_we    = 1'b1;
                            l_wdata = l_word + {{24{op_reg.inc[7]}}, op_reg.inc};
                        end
                        jvmx_pkg::K_RET:
                        begin
                            ret_next  = s_rdata;
                            stop_next = 1'b1;
                            sp_next   = sp_m1;
                        end
                        default:
                        begin
                            sp_next = sp_reg;
                        end
                    endcase
                end
            end
            ST_RD2:
            begin
                s_raddr = sp_m2;
                if (op_reg.kind == jvmx_pkg::K_MUL)
                begin
                    p_next     = s_rdata * a_reg;
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = ST_HEAD;
                    if (op_reg.kind == jvmx_pkg::K_CMPLT)
                    begin
                        sp_next   = sp_m2;
                        take_jump = ($signed(s_rdata) < $signed(a_reg));
                    end
                    else
                    begin
                        s_we    = 1'b1;
                        s_waddr = sp_m2;
                        s_wdata = (op_reg.kind == jvmx_pkg::K_SUB) ? s_rdata - a_reg
                                                                    : s_rdata + a_reg;
                        sp_next = sp_m1;
                    end
                end
            end
            ST_MUL:
            begin
                if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = ST_HEAD;
                    s_we       = 1'b1;
                    s_waddr    = sp_m2;
                    s_wdata    = p_reg;
                    sp_next    = sp_m1;
                end
            end
            default:
            begin
                state_next = ST_HEAD;
            end
        endcase

        // step counter holds once halted
        step_next = step_reg;
        if (fin && !stop_reg)
        begin
            step_next = take_jump ? cur.target : step_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HEAD;
            sp_reg        <= '0;
            step_reg      <= 16'd0;
            stop_reg      <= 1'b0;
            ret_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
            lval_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            step_reg  <= step_next;
            stop_reg  <= stop_next;
            ret_reg   <= ret_next;
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (l_we)
            begin
                lval_reg[l_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        p_reg       <= p_next;
        lval_rd_reg <= lval_reg[l_raddr];
        if (fin)
        begin
            out_reg.next_step    <= step_next;
            out_reg.halted       <= stop_next;
            out_reg.return_value <= ret_next;
        end
    end

    jvmx_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    jvmx_ram #(
        .WIDTH (32),
        .DEPTH (LOCAL_COUNT)
    ) u_local_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

[sv/jvm_subset_stack_executor.sv]
// ----------------------------------------------------------------------------
// jvm_subset_stack_executor
// integer subset jvm instruction executor with operand stack and locals
// ----------------------------------------------------------------------------
// finish state: pushes, goto, unknown opcodes and halted items finish in ST_HEAD;
//   loads, stores, iinc and ireturn in ST_RD1; add, sub and compare-branch in
//   ST_RD2; imul in ST_MUL, each into the registered result (plus queue wait)
// one item is executed at a time, paced by the one read port of the stack ram
//   and the registered multiplier stage; a full result register stalls it
// reset: control, stack pointer, step and return word clear; locals read zero
module jvm_subset_stack_executor #(
    parameter int STACK_DEPTH = 256,
    parameter int LOCAL_COUNT = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    // instruction channel
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  jvmx_pkg::cmd_t cmd_data,
    // result channel
    output logic           res_valid,
    input  logic           res_ready,
    output jvmx_pkg::res_t res_data
);

    // front to back queue head and pop strobe
    jvmx_pkg::queue_head_t head;
    logic                  pop;

    // front: classify each transfer and queue up to two decoded operations
    jvmx_front #(
        .LOCAL_COUNT (LOCAL_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .head      (head),
        .pop       (pop)
    );

    // back: sequence stack and local ram accesses, update step counter,
    // hold one result in the output register so the front keeps accepting;
    // locals read zero through per-entry valid flags, stack ram undefined
    jvmx_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .LOCAL_COUNT (LOCAL_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

[sv/jvmx_checker.sv]
// ----------------------------------------------------------------------------
// jvmx_checker
// port-level checks of the jvm subset stack executor, bound to the top level
// ----------------------------------------------------------------------------
`include "jvm_subset_stack_executor_macros.svh"

module jvmx_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input logic           res_valid,
    input logic           res_ready,
    input jvmx_pkg::res_t res_data
);

    logic        cmd_xfer;
    logic        res_xfer;
    logic [7:0]  pending_reg;
    logic        halt_seen_reg;
    logic [15:0] halt_step_reg;
    logic [31:0] halt_ret_reg;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign res_xfer = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 8'd0;
            halt_seen_reg <= 1'b0;
            halt_step_reg <= 16'd0;
            halt_ret_reg  <= 32'd0;
        end
        else
        begin
            pending_reg <= pending_reg + {7'd0, cmd_xfer} - {7'd0, res_xfer};
            if (res_xfer && res_data.halted && !halt_seen_reg)
            begin
                halt_seen_reg <= 1'b1;
                halt_step_reg <= res_data.next_step;
                halt_ret_reg  <= res_data.return_value;
            end
        end
    end

    `JVMX_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(res_data), "result changed while stalled")

    `JVMX_ASSERT_NOW(a_no_extra_result, res_valid, pending_reg != 8'd0,
        "result without a pending instruction")

    `JVMX_ASSERT_NOW(a_zero_before_halt, res_valid && !res_data.halted,
        res_data.return_value == 32'sd0, "return value nonzero before halt")

    `JVMX_ASSERT_NOW(a_halt_frozen, res_valid && halt_seen_reg,
        res_data.halted && res_data.next_step == halt_step_reg
        && res_data.return_value == halt_ret_reg, "result moved after halt")

endmodule

bind jvm_subset_stack_executor jvmx_checker u_jvmx_checker (.*);
